[rtl/tbi_pkg.sv]
package tbi_pkg;

  localparam int WORD_W = 32;

  // input word commands
  localparam logic [1:0] CMD_WR_FIRST  = 2'd0;
  localparam logic [1:0] CMD_WR_SECOND = 2'd1;
  localparam logic [1:0] CMD_WR_ENTRY  = 2'd2;
  localparam logic [1:0] CMD_QUERY     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SPAN = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_FIRST_COUNT  = 2'd0;
  localparam logic [1:0] CFG_SECOND_COUNT = 2'd1;
  localparam logic [1:0] CFG_SWAP_AXES    = 2'd2;

  // serial unit lengths
  localparam int MUL_DIGIT = 8;
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 34;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_ACCEPT = 4'd1;
  localparam op_t OP_PICK   = 4'd2;
  localparam op_t OP_MDEN   = 4'd3;
  localparam op_t OP_STEP   = 4'd4;
  localparam op_t OP_SAVE   = 4'd5;
  localparam op_t OP_CORNER = 4'd6;
  localparam op_t OP_MT     = 4'd7;
  localparam op_t OP_ACC    = 4'd8;
  localparam op_t OP_DIVS   = 4'd9;
  localparam op_t OP_DSTEP  = 4'd10;
  localparam op_t OP_ROUND  = 4'd11;
  localparam op_t OP_ERR    = 4'd12;
  localparam op_t OP_OUT    = 4'd13;

  typedef struct packed {
    op_t        op;
    logic [1:0] corner;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic zero_span;
  } dp_stat_t;

endpackage

[rtl/tbi_if.sv]
interface tbi_req_if;
  import tbi_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [2:0]         axis_pos;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [31:0] write_value;
  logic signed [31:0] first_coord;
  logic signed [31:0] second_coord;
  modport source(output valid, cmd, axis_pos, row, col, write_value, first_coord,
                 second_coord, input ready);
  modport sink(input valid, cmd, axis_pos, row, col, write_value, first_coord,
               second_coord, output ready);
endinterface

interface tbi_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_value;
  logic [1:0]         status;
  modport source(output valid, interp_value, status, input ready);
  modport sink(input valid, interp_value, status, output ready);
endinterface

interface tbi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/table_bilinear_interpolator_top.sv]
// Channel  Dir  Word
// req      in   cmd, axis_pos, row, col, write_value, first_coord, second_coord
// rsp      out  interp_value, status (one word per query)
// cfg      in   index, data (count registers and axis swap; always ready)
//
// A load word is written as it is accepted and leaves the block idle. A query
// runs from accept to result valid through a breakpoint scan over both axis
// memories, nine 4-pass products on one 8-bit-digit serial multiplier (span,
// then two per corner), and a 34-step restoring divider. A zero span skips
// the products and the divider and answers with status ST_SPAN.
// The result sits in an output register, so the next word is taken while it
// waits. Reset is synchronous; memories keep no reset state.
module table_bilinear_interpolator_top #(
  parameter int MAX_POINTS = 8
) (
  input logic clk,
  input logic rst,
  tbi_req_if.sink   req,
  tbi_rsp_if.source rsp,
  tbi_cfg_if.sink   cfg
);
  import tbi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config writes are taken on any cycle
  assign cfg.ready = 1'b1;

  // sequencer
  tbi_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .in_is_query(req.cmd == CMD_QUERY),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd, .stat
  );

  // memories, search, multiplier, divider
  tbi_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .cmd_code(req.cmd), .axis_pos(req.axis_pos), .row(req.row), .col(req.col),
    .write_value(req.write_value), .first_coord(req.first_coord),
    .second_coord(req.second_coord),
    .cfg_wr(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .interp_value(rsp.interp_value), .status(rsp.status)
  );

endmodule

[rtl/tbi_axis.sv]
module tbi_axis #(
  parameter int MAX_POINTS = 8,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int NW = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_pos,
  input  logic signed [31:0]   wr_val,
  input  logic                 start,
  input  logic signed [31:0]   coord,
  input  logic [NW-1:0]        n,
  output logic                 done,
  output logic [IW-1:0]        lo_idx,
  output logic [IW-1:0]        hi_idx,
  output logic signed [31:0]   lo_val,
  output logic signed [31:0]   hi_val
);

  logic signed [31:0] mem [MAX_POINTS];
  logic signed [31:0] rdata, prev, p0, p1, plast, pprev, f_lov, f_hiv;
  logic [NW-1:0]      k;
  logic               ev, found, in_range, is_last, hit;
  logic [IW-1:0]      ev_idx, f_lo;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos] <= wr_val;
    end
  end

  assign in_range = NW'(ev_idx) < n;
  assign is_last  = (NW'(ev_idx) + NW'(1)) == n;
  assign hit = ev && in_range && (ev_idx != '0) && !found &&
               (prev <= coord) && (coord <= rdata);

  // scan walks every slot once, one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= NW'(MAX_POINTS);
      ev    <= 1'b0;
      found <= 1'b0;
    end else if (start) begin
      k     <= '0;
      ev    <= 1'b0;
      found <= 1'b0;
    end else begin
      if (k < NW'(MAX_POINTS)) begin
        ev <= 1'b1;
        k  <= k + NW'(1);
      end else begin
        ev <= 1'b0;
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (k < NW'(MAX_POINTS)) begin
      rdata  <= mem[k[IW-1:0]];
      ev_idx <= k[IW-1:0];
    end
    if (ev) begin
      if (ev_idx == IW'(0)) p0 <= rdata;
      if (ev_idx == IW'(1)) p1 <= rdata;
      if (hit) begin
        f_lo  <= ev_idx - IW'(1);
        f_lov <= prev;
        f_hiv <= rdata;
      end
      if (is_last) begin
        plast <= rdata;
        pprev <= prev;
      end
      prev <= rdata;
    end
  end

  assign done = (k == NW'(MAX_POINTS)) && !ev;

  always_comb begin
    if (coord < p0) begin
      lo_idx = '0;
      hi_idx = IW'(1);
      lo_val = p0;
      hi_val = p1;
    end else if (coord > plast) begin
      lo_idx = IW'(n - NW'(2));
      hi_idx = IW'(n - NW'(1));
      lo_val = pprev;
      hi_val = plast;
    end else if (found) begin
      lo_idx = f_lo;
      hi_idx = f_lo + IW'(1);
      lo_val = f_lov;
      hi_val = f_hiv;
    end else begin
      // unordered list: degenerate pair
      lo_idx = '0;
      hi_idx = '0;
      lo_val = p0;
      hi_val = p0;
    end
  end

endmodule

[rtl/tbi_datapath.sv]
module tbi_datapath #(
  parameter int MAX_POINTS = 8,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int NW = $clog2(MAX_POINTS + 1),
  localparam int AW = $clog2(MAX_POINTS * MAX_POINTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tbi_pkg::dp_cmd_t     cmd,
  output tbi_pkg::dp_stat_t    stat,
  input  logic [1:0]           cmd_code,
  input  logic [2:0]           axis_pos,
  input  logic [2:0]           row,
  input  logic [2:0]           col,
  input  logic signed [31:0]   write_value,
  input  logic signed [31:0]   first_coord,
  input  logic signed [31:0]   second_coord,
  input  logic                 cfg_wr,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data,
  output logic signed [31:0]   interp_value,
  output logic [1:0]           status
);
  import tbi_pkg::*;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? -v : v;
    return t[31:0];
  endfunction

  function automatic logic [NW-1:0] eff_count(input logic [3:0] c);
    if (int'(c) < 2) return NW'(2);
    if (int'(c) > MAX_POINTS) return NW'(MAX_POINTS);
    return NW'(c);
  endfunction

  logic [3:0]         cnt1, cnt2;
  logic               swap;
  logic signed [31:0] qx, qy;
  logic [NW-1:0]      n1, n2;
  logic               acc_q, start, wr1, wr2, wr_t;
  logic               done1, done2;
  logic [IW-1:0]      lo1, hi1, lo2, hi2, i1, i2, j1, j2;
  logic signed [31:0] lv1, hv1, lv2, hv2, x1, x2, y1, y2;
  logic signed [32:0] dx, dy, ax_hi, ax_lo, ay_hi, ay_lo, ax_sel, ay_sel;
  logic signed [31:0] tmem [MAX_POINTS*MAX_POINTS];
  logic signed [31:0] trd, res_val;
  logic [1:0]         res_st;
  logic [AW-1:0]      waddr, raddr;
  logic [87:0]        ma;
  logic [31:0]        mb, tmag;
  logic [95:0]        macc;
  logic [63:0]        den;
  logic               tneg, nneg, neg, rup, sat;
  logic signed [99:0] num;
  logic [98:0]        rem;
  logic [96:0]        dd;
  logic [33:0]        q, qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt1 <= 4'd8;
      cnt2 <= 4'd8;
      swap <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_FIRST_COUNT:  cnt1 <= cfg_data;
        CFG_SECOND_COUNT: cnt2 <= cfg_data;
        CFG_SWAP_AXES:    swap <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign acc_q = (cmd.op == OP_ACCEPT);
  assign start = acc_q && (cmd_code == CMD_QUERY);
  assign wr1   = acc_q && (cmd_code == CMD_WR_FIRST) && (int'(axis_pos) < MAX_POINTS);
  assign wr2   = acc_q && (cmd_code == CMD_WR_SECOND) && (int'(axis_pos) < MAX_POINTS);
  assign wr_t  = acc_q && (cmd_code == CMD_WR_ENTRY) && (int'(row) < MAX_POINTS) &&
                 (int'(col) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (start) begin
      qx <= swap ? second_coord : first_coord;
      qy <= swap ? first_coord : second_coord;
      n1 <= eff_count(cnt1);
      n2 <= eff_count(cnt2);
    end
  end

  tbi_axis #(.MAX_POINTS(MAX_POINTS)) u_axis1 (
    .clk, .rst, .wr_en(wr1), .wr_pos(IW'(axis_pos)), .wr_val(write_value), .start,
    .coord(qx), .n(n1), .done(done1), .lo_idx(lo1), .hi_idx(hi1), .lo_val(lv1),
    .hi_val(hv1)
  );

  tbi_axis #(.MAX_POINTS(MAX_POINTS)) u_axis2 (
    .clk, .rst, .wr_en(wr2), .wr_pos(IW'(axis_pos)), .wr_val(write_value), .start,
    .coord(qy), .n(n2), .done(done2), .lo_idx(lo2), .hi_idx(hi2), .lo_val(lv2),
    .hi_val(hv2)
  );

  assign waddr = AW'(AW'(row) * AW'(MAX_POINTS) + AW'(col));
  assign raddr = AW'(AW'(cmd.corner[1] ? i2 : i1) * AW'(MAX_POINTS) +
                 AW'(cmd.corner[0] ? j2 : j1));

  always_ff @(posedge clk) begin
    if (wr_t) begin
      tmem[waddr] <= write_value;
    end
  end

  assign dx     = 33'(x2) - 33'(x1);
  assign dy     = 33'(y2) - 33'(y1);
  assign ax_hi  = 33'(x2) - 33'(qx);
  assign ax_lo  = 33'(qx) - 33'(x1);
  assign ay_hi  = 33'(y2) - 33'(qy);
  assign ay_lo  = 33'(qy) - 33'(y1);
  assign ax_sel = cmd.corner[1] ? ax_lo : ax_hi;
  assign ay_sel = cmd.corner[0] ? ay_lo : ay_hi;
  assign tmag   = trd[31] ? 32'(-trd) : 32'(trd);

  assign stat.srch_done = done1 && done2;
  assign stat.zero_span = (dx == '0) || (dy == '0);

  // rounding and clamp
  assign rup = {rem[64:0], 1'b0} >= 66'(den);
  assign qr  = {1'b0, q[32:0]} + 34'(rup);
  assign neg = nneg ^ dx[32] ^ dy[32];
  assign sat = q[33] || (neg ? (qr > 34'h080000000) : (qr > 34'h07FFFFFFF));

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PICK: begin
        i1 <= lo1; i2 <= hi1; x1 <= lv1; x2 <= hv1;
        j1 <= lo2; j2 <= hi2; y1 <= lv2; y2 <= hv2;
      end
      OP_MDEN: begin
        ma   <= 88'(mag33(dx));
        mb   <= mag33(dy);
        macc <= '0;
        num  <= '0;
      end
      OP_STEP: begin
        macc <= macc + 96'(ma) * 96'(mb[MUL_DIGIT-1:0]);
        ma   <= ma << MUL_DIGIT;
        mb   <= mb >> MUL_DIGIT;
      end
      OP_SAVE: den <= macc[63:0];
      OP_CORNER: begin
        ma   <= 88'(mag33(ax_sel));
        mb   <= mag33(ay_sel);
        macc <= '0;
        tneg <= ax_sel[32] ^ ay_sel[32];
        trd  <= tmem[raddr];
      end
      OP_MT: begin
        ma   <= 88'(macc[63:0]);
        mb   <= tmag;
        macc <= '0;
        tneg <= tneg ^ trd[31];
      end
      OP_ACC: num <= tneg ? num - 100'(macc) : num + 100'(macc);
      OP_DIVS: begin
        nneg <= num[99];
        rem  <= num[99] ? 99'(-num) : 99'(num);
        dd   <= {den, 33'b0};
        q    <= '0;
      end
      OP_DSTEP: begin
        if (rem >= 99'(dd)) begin
          rem <= rem - 99'(dd);
          q   <= {q[32:0], 1'b1};
        end else begin
          q   <= {q[32:0], 1'b0};
        end
        dd <= dd >> 1;
      end
      OP_ROUND: begin
        res_st <= sat ? ST_SAT : ST_OK;
        if (sat) res_val <= neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else     res_val <= neg ? 32'(-qr) : qr[31:0];
      end
      OP_ERR: begin
        res_val <= '0;
        res_st  <= ST_SPAN;
      end
      OP_OUT: begin
        interp_value <= res_val;
        status       <= res_st;
      end
      default: ;
    endcase
  end

endmodule

[rtl/tbi_ctrl.sv]
module tbi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_is_query,
  output logic               out_valid,
  input  logic               out_ready,
  output tbi_pkg::dp_cmd_t   cmd,
  input  tbi_pkg::dp_stat_t  stat
);
  import tbi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_PICK = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_MDEN = 4'd4;
  localparam logic [3:0] S_SAVE = 4'd5;
  localparam logic [3:0] S_CRN  = 4'd6;
  localparam logic [3:0] S_MAB  = 4'd7;
  localparam logic [3:0] S_MTS  = 4'd8;
  localparam logic [3:0] S_MT   = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_DIVS = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_RND  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] corner, corner_next;
  logic       mul_last, div_last;

  assign mul_last = (cnt == 6'(MUL_STEPS - 1));
  assign div_last = (cnt == 6'(DIV_STEPS - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt + 6'd1;
    corner_next = corner;
    cmd.op      = OP_NONE;
    cmd.corner  = corner;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_is_query) state_next = S_SRCH;
        end
      end
      S_SRCH: if (stat.srch_done) state_next = S_PICK;
      S_PICK: begin
        cmd.op = OP_PICK;
        state_next = S_CHK;
      end
      S_CHK: begin
        cnt_next = '0;
        if (stat.zero_span) begin
          cmd.op = OP_ERR;
          state_next = S_FIN;
        end else begin
          cmd.op = OP_MDEN;
          state_next = S_MDEN;
        end
      end
      S_MDEN: begin
        cmd.op = OP_STEP;
        if (mul_last) state_next = S_SAVE;
      end
      S_SAVE: begin
        cmd.op = OP_SAVE;
        corner_next = '0;
        state_next = S_CRN;
      end
      S_CRN: begin
        cmd.op = OP_CORNER;
        cnt_next = '0;
        state_next = S_MAB;
      end
      S_MAB: begin
        cmd.op = OP_STEP;
        if (mul_last) state_next = S_MTS;
      end
      S_MTS: begin
        cmd.op = OP_MT;
        cnt_next = '0;
        state_next = S_MT;
      end
      S_MT: begin
        cmd.op = OP_STEP;
        if (mul_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (corner == 2'd3) begin
          state_next = S_DIVS;
        end else begin
          corner_next = corner + 2'd1;
          state_next = S_CRN;
        end
      end
      S_DIVS: begin
        cmd.op = OP_DIVS;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DSTEP;
        if (div_last) state_next = S_RND;
      end
      S_RND: begin
        cmd.op = OP_ROUND;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      corner    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      corner <= corner_next;
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

endmodule

[tb/table_bilinear_interpolator_top_tb.sv]
`timescale 1ns / 1ps

module table_bilinear_interpolator_top_tb;
  import tbi_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } interp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tbi_req_if req_if();
  tbi_rsp_if rsp_if();
  tbi_cfg_if cfg_if();

  table_bilinear_interpolator_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block state, updated as each word is accepted.
  logic signed [31:0] first_pts [8];
  logic signed [31:0] second_pts [8];
  logic signed [31:0] entries [8][8];
  logic [3:0]         first_cnt;
  logic [3:0]         second_cnt;
  logic               swap_xy;

  interp_t pending_results[$];

  int idle_pct  = 0;   // sender gap chance per word
  int stall_pct = 0;   // receiver stall chance per cycle
  int errors    = 0;
  int n_queries = 0;
  int n_loads   = 0;
  int n_span    = 0;
  int n_sat     = 0;
  int n_checked = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic int clamp_count(logic [3:0] c);
    if (c < 2) return 2;
    if (c > 8) return 8;
    return c;
  endfunction

  // Pick the bracketing breakpoint pair; end pairs extrapolate.
  function automatic void find_pair(input bit second_axis, input logic signed [31:0] c,
                                    output int lo, output int hi);
    logic signed [31:0] p [8];
    int n;
    n = clamp_count(second_axis ? second_cnt : first_cnt);
    if (second_axis) p = second_pts;
    else p = first_pts;
    lo = 0;
    hi = 0;
    if (c < p[0]) begin
      hi = 1;
    end else if (c > p[n-1]) begin
      lo = n - 2;
      hi = n - 1;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (p[i] <= c && c <= p[i+1]) begin
          lo = i;
          hi = i + 1;
          break;
        end
      end
    end
  endfunction

  function automatic interp_t interpolate(logic signed [31:0] c1, logic signed [31:0] c2);
    interp_t r;
    int i1, i2, j1, j2;
    logic signed [127:0] x, y, x1, x2, y1, y2, num, den;
    logic [127:0] an, ad, q, rem;
    bit neg;
    if (swap_xy) begin
      x = c2;
      y = c1;
    end else begin
      x = c1;
      y = c2;
    end
    find_pair(1'b0, x[31:0], i1, i2);
    find_pair(1'b1, y[31:0], j1, j2);
    x1 = first_pts[i1];
    x2 = first_pts[i2];
    y1 = second_pts[j1];
    y2 = second_pts[j2];
    if (x2 == x1 || y2 == y1) begin
      r.value  = '0;
      r.status = ST_SPAN;
      return r;
    end
    num = (x2 - x) * (y2 - y) * 128'(entries[i1][j1])
        + (x2 - x) * (y - y1) * 128'(entries[i1][j2])
        + (x - x1) * (y2 - y) * 128'(entries[i2][j1])
        + (x - x1) * (y - y1) * 128'(entries[i2][j2]);
    den = (x2 - x1) * (y2 - y1);
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = an / ad;
    rem = an % ad;
    if ((rem << 1) >= ad) q = q + 1;   // nearest, ties away from zero
    if ((neg && q > 128'h8000_0000) || (!neg && q > 128'h7FFF_FFFF)) begin
      r.status = ST_SAT;
      r.value  = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r.status = ST_OK;
      r.value  = neg ? -q[31:0] : q[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Inputs are driven at the rising edge, so sampling at the falling edge
  // sees exactly what the next rising edge will accept.
  always @(negedge clk) begin
    interp_t exp_r;
    if (!rst) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: value %0d status %0d", $time,
                   rsp_if.interp_value, rsp_if.status);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          n_checked++;
          if (rsp_if.interp_value !== exp_r.value) begin
            $display("%0t interp_value: expected %0d actual %0d", $time,
                     exp_r.value, rsp_if.interp_value);
            errors++;
          end
          if (rsp_if.status !== exp_r.status) begin
            $display("%0t status: expected %0d actual %0d", $time,
                     exp_r.status, rsp_if.status);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Send one word; called just after a rising edge.
  task automatic send_word(logic [1:0] cmd, logic [2:0] pos, logic [2:0] row,
                           logic [2:0] col, logic signed [31:0] wv,
                           logic signed [31:0] c1, logic signed [31:0] c2);
    bit hs;
    interp_t r;
    if ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.axis_pos     <= pos;
    req_if.row          <= row;
    req_if.col          <= col;
    req_if.write_value  <= wv;
    req_if.first_coord  <= c1;
    req_if.second_coord <= c2;
    do begin
      @(negedge clk);
      hs = req_if.ready;
      @(posedge clk);
    end while (!hs);
    case (cmd)
      CMD_WR_FIRST:  first_pts[pos] = wv;
      CMD_WR_SECOND: second_pts[pos] = wv;
      CMD_WR_ENTRY:  entries[row][col] = wv;
      CMD_QUERY: begin
        r = interpolate(c1, c2);
        pending_results = {pending_results, r};
        n_queries++;
        if (r.status == ST_SPAN) n_span++;
        if (r.status == ST_SAT) n_sat++;
      end
    endcase
    if (cmd != CMD_QUERY) n_loads++;
  endtask

  task automatic query(logic signed [31:0] c1, logic signed [31:0] c2);
    send_word(CMD_QUERY, 3'($urandom), 3'($urandom), 3'($urandom), $urandom, c1, c2);
  endtask

  // Let everything in flight come out, then give the block time to settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [3:0] data);
    bit hs;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do begin
      @(negedge clk);
      hs = cfg_if.ready;
      @(posedge clk);
    end while (!hs);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_FIRST_COUNT:  first_cnt = data;
      CFG_SECOND_COUNT: second_cnt = data;
      CFG_SWAP_AXES:    swap_xy = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Ascending breakpoints unless scrambled; wide spreads over the full range, else tight.
  task automatic load_axis(logic [1:0] cmd, bit wide, bit scramble);
    logic signed [31:0] p [8];
    logic signed [31:0] t;
    if (wide) begin
      foreach (p[i]) p[i] = $urandom;
      for (int i = 0; i < 8; i++)
        for (int j = 0; j < 7 - i; j++)
          if (p[j] > p[j+1]) begin
            t = p[j];
            p[j] = p[j+1];
            p[j+1] = t;
          end
    end else begin
      p[0] = $signed($urandom_range(2097152)) - 1048576;
      for (int i = 1; i < 8; i++) p[i] = p[i-1] + $urandom_range(1, 262144);
    end
    if (scramble) begin
      // either a duplicate breakpoint or an out-of-order one
      if ($urandom_range(1)) p[$urandom_range(1, 7)] = p[0];
      else p[$urandom_range(7)] = $urandom;
    end
    foreach (p[i])
      send_word(cmd, 3'(i), 3'($urandom), 3'($urandom), p[i], $urandom, $urandom);
  endtask

  task automatic load_entries(int mag);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send_word(CMD_WR_ENTRY, 3'($urandom), 3'(r), 3'(c),
                  (mag == 0) ? $urandom : $signed($urandom_range(2 * mag)) - mag,
                  $urandom, $urandom);
  endtask

  task automatic load_all(bit wide, int mag);
    load_axis(CMD_WR_FIRST, wide, 1'b0);
    load_axis(CMD_WR_SECOND, wide, 1'b0);
    load_entries(mag);
  endtask

  // Coordinate near the axis in use: on a breakpoint, between, or outside.
  function automatic logic signed [31:0] pick_coord(bit second_axis);
    logic signed [31:0] p [8];
    longint lo, hi, span, v;
    int n;
    if (second_axis) p = second_pts;
    else p = first_pts;
    n = clamp_count(second_axis ? second_cnt : first_cnt);
    case ($urandom_range(9))
      0, 1: return p[$urandom_range(7)];
      2:    return $urandom;
      default: begin
        lo = p[0];
        hi = p[n-1];
        span = (hi > lo ? hi - lo : 64'd1024);
        v = lo - span / 4 + longint'({$urandom, $urandom} % (span + span / 2 + 1));
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        return v[31:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    load_all(1'b0, 1 << 20);
    query(first_pts[0], second_pts[0]);                 // exact corners
    query(first_pts[7], second_pts[7]);
    query(first_pts[3], second_pts[4]);                 // interior breakpoints
    query((first_pts[2] + first_pts[3]) / 2, (second_pts[5] + second_pts[6]) / 2);
    query(32'sh8000_0000, 32'sh8000_0000);              // far below both axes
    query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);              // far above both axes
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh0000_0000, 32'shFFFF_FFFF);
    drain();
    cfg_write(CFG_SWAP_AXES, 4'd1);                     // swapped coordinates
    query(first_pts[1], second_pts[6]);
    query(second_pts[2], first_pts[5]);
    drain();
    cfg_write(CFG_SWAP_AXES, 4'd0);
  endtask

  task automatic test_zero_span();
    // duplicate first breakpoint: anything below or on it has no span
    send_word(CMD_WR_FIRST, 3'd1, 3'($urandom), 3'($urandom), first_pts[0], 0, 0);
    query(first_pts[0] - 5, second_pts[3]);
    query(first_pts[0], second_pts[3]);
    send_word(CMD_WR_SECOND, 3'd7, 3'($urandom), 3'($urandom), second_pts[6], 0, 0);
    query(first_pts[4], 32'sh7FFF_FFFF);
    drain();
  endtask

  task automatic test_unsorted_axis();
    // descending list: a coordinate below the first entry takes the first pair, any other the last
    for (int i = 0; i < 8; i++)
      send_word(CMD_WR_SECOND, 3'(i), 3'($urandom), 3'($urandom), 1000 - 100 * i, 0, 0);
    query(first_pts[2], 500);
    query(first_pts[2], 2000);
    query(first_pts[2], -5000);
    drain();
  endtask

  task automatic test_saturation();
    load_axis(CMD_WR_FIRST, 1'b0, 1'b0);
    load_axis(CMD_WR_SECOND, 1'b0, 1'b0);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send_word(CMD_WR_ENTRY, 3'($urandom), 3'(r), 3'(c),
                  ((r + c) % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF, 0, 0);
    query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh8000_0000, 32'sh8000_0000);
    query(first_pts[0], second_pts[0]);
    drain();
  endtask

  task automatic test_count_extremes();
    logic [3:0] counts [6] = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd15};
    load_all(1'b1, 0);
    drain();
    foreach (counts[i]) begin
      cfg_write(CFG_FIRST_COUNT, counts[i]);
      cfg_write(CFG_SECOND_COUNT, counts[5 - i]);
      query(pick_coord(1'b0), pick_coord(1'b1));
      query(32'sh7FFF_FFFF, 32'sh8000_0000);
      drain();
    end
  endtask

  // Mostly queries over freshly loaded tables, some reloads and noise.
  task automatic test_random(int n_words, int idle, int stall);
    int sel;
    idle_pct  = idle;
    stall_pct = stall;
    cfg_write(CFG_FIRST_COUNT, 4'($urandom_range(15)));
    cfg_write(CFG_SECOND_COUNT, 4'($urandom_range(15)));
    cfg_write(CFG_SWAP_AXES, 4'($urandom_range(1)));
    load_all(1'($urandom_range(1)),
             $urandom_range(1) ? 0 : (1 << $urandom_range(8, 30)));
    for (int k = 0; k < n_words; k++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        load_axis($urandom_range(1) ? CMD_WR_SECOND : CMD_WR_FIRST,
                  1'($urandom_range(1)), $urandom_range(7) == 0);
      end else if (sel < 18) begin
        send_word(CMD_WR_ENTRY, 3'($urandom), 3'($urandom), 3'($urandom), $urandom,
                  $urandom, $urandom);
      end else if (sel < 22) begin
        send_word($urandom_range(1) ? CMD_WR_SECOND : CMD_WR_FIRST, 3'($urandom),
                  3'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
      end else begin
        query(pick_coord(1'b0), pick_coord(1'b1));
      end
    end
    drain();
  endtask

  initial begin
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_QUERY;
    req_if.axis_pos     <= '0;
    req_if.row          <= '0;
    req_if.col          <= '0;
    req_if.write_value  <= '0;
    req_if.first_coord  <= '0;
    req_if.second_coord <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_FIRST_COUNT;
    cfg_if.data         <= '0;
    first_cnt  = 4'd8;
    second_cnt = 4'd8;
    swap_xy    = 1'b0;
    foreach (first_pts[i]) begin
      first_pts[i]  = '0;
      second_pts[i] = '0;
    end
    foreach (entries[i, j]) entries[i][j] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_span();
    test_unsorted_axis();
    test_saturation();
    test_count_extremes();
    test_random(300, 0, 0);
    test_random(300, 61, 0);
    test_random(300, 0, 61);
    test_random(300, 37, 37);

    $display("Ran %0d queries (%0d zero span, %0d saturated) and %0d load words;",
             n_queries, n_span, n_sat, n_loads);
    $display("%0d results checked over four idle/stall phases.", n_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
